// ===== rtl/lc3b_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3b_pkg
// Shared types and constants for the LC-3b instruction executor.
// ----------------------------------------------------------------------------
package lc3b_pkg;

	localparam int MEM_WORDS = 32768;
	localparam int MEM_AW    = $clog2(MEM_WORDS);
	localparam int NUM_REGS  = 8;
	localparam int RF_AW     = $clog2(NUM_REGS);
	localparam int QDEPTH    = 2;

	typedef enum logic [1:0] {
		KIND_LOAD = 2'd0,
		KIND_EXEC = 2'd1,
		KIND_READ = 2'd2,
		KIND_NONE = 2'd3
	} item_kind_t;

	typedef enum logic [3:0] {
		OP_BR = 4'd0, OP_ADD = 4'd1, OP_LDB = 4'd2, OP_STB = 4'd3,
		OP_JSR = 4'd4, OP_AND = 4'd5, OP_LDW = 4'd6, OP_STW = 4'd7,
		OP_RTI = 4'd8, OP_XOR = 4'd9, OP_R10 = 4'd10, OP_R11 = 4'd11,
		OP_JMP = 4'd12, OP_SHF = 4'd13, OP_LEA = 4'd14, OP_TRAP = 4'd15
	} op_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [15:0] address;
		logic [15:0] data;
	} in_item_t;

	typedef struct packed {
		logic [15:0] pc;
		logic        cond_neg;
		logic        cond_zero;
		logic        cond_pos;
		logic        halted;
		logic [15:0] read_data;
		logic        reg_written;
		logic [2:0]  reg_index;
		logic [15:0] reg_value;
		logic        mem_written;
		logic [15:0] mem_address;
		logic [15:0] mem_value;
	} out_item_t;

	typedef struct packed {
		item_kind_t  kind;
		logic [15:0] address;
		logic [15:0] data;
		logic        in_range;
	} q_item_t;

	function automatic logic addr_in_range(input logic [15:0] a);
		return {1'b0, a[15:1]} < 16'(MEM_WORDS);
	endfunction

	function automatic logic [MEM_AW-1:0] word_idx(input logic [15:0] a);
		logic [16:0] w;
		w = {2'b00, a[15:1]};
		return w[MEM_AW-1:0];
	endfunction

endpackage

// ===== rtl/lc3b_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3b_front
// Accepts input transactions, classifies them and queues them for the back end.
// ----------------------------------------------------------------------------
module lc3b_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lc3b_pkg::in_item_t  in_data,
	output logic                q_valid,
	input  logic                q_ready,
	output lc3b_pkg::q_item_t   q_data
);

	lc3b_pkg::q_item_t ent_q [lc3b_pkg::QDEPTH];
	logic        wp_q, rp_q;
	logic [1:0]  cnt_q;
	logic        push, pop;

	assign in_ready = (cnt_q != 2'(lc3b_pkg::QDEPTH));
	assign q_valid  = (cnt_q != 2'd0);
	assign q_data   = ent_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_valid && q_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wp_q].kind     <= lc3b_pkg::item_kind_t'(in_data.kind);
			ent_q[wp_q].address  <= in_data.address;
			ent_q[wp_q].data     <= in_data.data;
			ent_q[wp_q].in_range <= lc3b_pkg::addr_in_range(in_data.address);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== rtl/lc3b_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3b_back
// Executes queued transactions against main memory and the register file.
// ----------------------------------------------------------------------------
module lc3b_back (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [15:0]         start_pc,
	input  logic                q_valid,
	output logic                q_ready,
	input  lc3b_pkg::q_item_t   q_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lc3b_pkg::out_item_t out_data
);

	typedef enum logic [5:0] {
		ST_CLEAR = 6'b000001,
		ST_IDLE  = 6'b000010,
		ST_RDW   = 6'b000100,
		ST_FETCH = 6'b001000,
		ST_EXEC  = 6'b010000,
		ST_MEMW  = 6'b100000
	} state_t;

	state_t st_q, st_d;
	logic [lc3b_pkg::MEM_AW-1:0] clr_q;

	logic [15:0] mem [lc3b_pkg::MEM_WORDS];
	logic        m_we, m_re;
	logic [lc3b_pkg::MEM_AW-1:0] m_addr;
	logic [15:0] m_wd, m_rd_q, rdw;
	logic        rd_ok_q, rd_ok_d;

	logic [15:0] rf_q [lc3b_pkg::NUM_REGS];
	logic [lc3b_pkg::NUM_REGS-1:0] rf_vld_q;
	logic        rf_we;
	logic [lc3b_pkg::RF_AW-1:0] rf_wa;
	logic [15:0] rf_wd;

	logic [15:0] pc_q, pc_d, pc_eff;
	logic        n_q, z_q, p_q, started_q;
	logic [2:0]  cc_d;
	logic        cc_we;
	logic        started_set;

	logic [15:0] ir_q, ra_q, rb_q, ea_q, ea_d;
	logic        ea_ld, ir_ld;
	logic [lc3b_pkg::RF_AW-1:0] ra_idx, rb_idx;

	lc3b_pkg::out_item_t out_q, o;
	logic        out_vld_q, out_free, done;

	lc3b_pkg::op_t op, fop;
	logic [15:0] npc, off9, off11, imm5, imm6, b_op, ea_b, ea_w, shf, alu;
	logic        br_taken;

	function automatic logic [2:0] codes(input logic [15:0] v);
		return {v[15], v == 16'd0, (v != 16'd0) && !v[15]};
	endfunction

	assign out_valid = out_vld_q;
	assign out_data  = out_q;
	assign out_free  = !out_vld_q || out_ready;
	assign rdw       = rd_ok_q ? m_rd_q : 16'd0;
	assign pc_eff    = started_q ? pc_q : start_pc;

	assign op    = lc3b_pkg::op_t'(ir_q[15:12]);
	assign fop   = lc3b_pkg::op_t'(rdw[15:12]);
	assign ra_idx = rdw[8:6];
	assign rb_idx = (fop == lc3b_pkg::OP_STB || fop == lc3b_pkg::OP_STW) ?
		rdw[11:9] : rdw[2:0];

	assign npc   = pc_q + 16'd2;
	assign off9  = {{6{ir_q[8]}}, ir_q[8:0], 1'b0};
	assign off11 = {{4{ir_q[10]}}, ir_q[10:0], 1'b0};
	assign imm5  = {{11{ir_q[4]}}, ir_q[4:0]};
	assign imm6  = {{10{ir_q[5]}}, ir_q[5:0]};
	assign b_op  = ir_q[5] ? imm5 : rb_q;
	assign ea_b  = ra_q + imm6;
	assign ea_w  = ra_q + {imm6[14:0], 1'b0};
	assign br_taken = (ir_q[11] & n_q) | (ir_q[10] & z_q) | (ir_q[9] & p_q);

	always_comb begin
		if (!ir_q[4])
			shf = ra_q << ir_q[3:0];
		else if (!ir_q[5])
			shf = ra_q >> ir_q[3:0];
		else
			shf = 16'($signed(ra_q) >>> ir_q[3:0]);
	end

	always_comb begin
		case (op)
			lc3b_pkg::OP_ADD: alu = ra_q + b_op;
			lc3b_pkg::OP_AND: alu = ra_q & b_op;
			default:          alu = ra_q ^ b_op;
		endcase
	end

	always_comb begin
		st_d = st_q;
		q_ready = 1'b0;
		m_we = 1'b0;
		m_re = 1'b0;
		m_addr = '0;
		m_wd = 16'd0;
		rd_ok_d = rd_ok_q;
		rf_we = 1'b0;
		rf_wa = '0;
		rf_wd = 16'd0;
		pc_d = pc_q;
		cc_we = 1'b0;
		cc_d = {n_q, z_q, p_q};
		started_set = 1'b0;
		ea_ld = 1'b0;
		ea_d = ea_q;
		ir_ld = 1'b0;
		done = 1'b0;
		o = '0;
		o.pc = pc_q;
		o.cond_neg = n_q;
		o.cond_zero = z_q;
		o.cond_pos = p_q;

		unique case (st_q)
			ST_CLEAR: begin
				m_we = 1'b1;
				m_addr = clr_q;
				if (clr_q == lc3b_pkg::MEM_AW'(lc3b_pkg::MEM_WORDS - 1)) st_d = ST_IDLE;
			end
			ST_IDLE: begin
				if (q_valid) begin
					case (q_data.kind)
						lc3b_pkg::KIND_LOAD: begin
							if (out_free) begin
								q_ready = 1'b1;
								done = 1'b1;
								m_we = q_data.in_range;
								m_addr = lc3b_pkg::word_idx(q_data.address);
								m_wd = q_data.data;
							end
						end
						lc3b_pkg::KIND_READ: begin
							q_ready = 1'b1;
							m_re = 1'b1;
							m_addr = lc3b_pkg::word_idx(q_data.address);
							rd_ok_d = q_data.in_range;
							st_d = ST_RDW;
						end
						lc3b_pkg::KIND_EXEC: begin
							if (pc_eff != 16'd0) begin
								q_ready = 1'b1;
								started_set = 1'b1;
								pc_d = pc_eff;
								m_re = 1'b1;
								m_addr = lc3b_pkg::word_idx(pc_eff);
								rd_ok_d = lc3b_pkg::addr_in_range(pc_eff);
								st_d = ST_FETCH;
							end else if (out_free) begin
								q_ready = 1'b1;
								started_set = 1'b1;
								pc_d = pc_eff;
								done = 1'b1;
								o.pc = pc_eff;
								o.halted = 1'b1;
							end
						end
						default: begin
							if (out_free) begin
								q_ready = 1'b1;
								done = 1'b1;
							end
						end
					endcase
				end
			end
			ST_RDW: begin
				if (out_free) begin
					done = 1'b1;
					o.read_data = rdw;
					st_d = ST_IDLE;
				end
			end
			ST_FETCH: begin
				ir_ld = 1'b1;
				st_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (op == lc3b_pkg::OP_LDB || op == lc3b_pkg::OP_STB ||
					op == lc3b_pkg::OP_LDW) begin
					ea_d = (op == lc3b_pkg::OP_LDW) ? ea_w : ea_b;
					ea_ld = 1'b1;
					m_re = 1'b1;
					m_addr = lc3b_pkg::word_idx(ea_d);
					rd_ok_d = lc3b_pkg::addr_in_range(ea_d);
					st_d = ST_MEMW;
				end else if (out_free) begin
					done = 1'b1;
					st_d = ST_IDLE;
					pc_d = npc;
					unique case (op)
						lc3b_pkg::OP_BR: if (br_taken) pc_d = npc + off9;
						lc3b_pkg::OP_ADD, lc3b_pkg::OP_AND, lc3b_pkg::OP_XOR,
						lc3b_pkg::OP_SHF: begin
							rf_we = 1'b1;
							rf_wa = ir_q[11:9];
							rf_wd = (op == lc3b_pkg::OP_SHF) ? shf : alu;
							cc_we = 1'b1;
						end
						lc3b_pkg::OP_JSR: begin
							rf_we = 1'b1;
							rf_wa = 3'd7;
							rf_wd = npc;
							pc_d = ir_q[11] ? npc + off11 : ra_q;
						end
						lc3b_pkg::OP_STW: begin
							m_we = lc3b_pkg::addr_in_range(ea_w);
							m_addr = lc3b_pkg::word_idx(ea_w);
							m_wd = rb_q;
							o.mem_written = m_we;
							o.mem_address = m_we ? ea_w : 16'd0;
							o.mem_value = m_we ? rb_q : 16'd0;
						end
						lc3b_pkg::OP_JMP: pc_d = ra_q;
						lc3b_pkg::OP_LEA: begin
							rf_we = 1'b1;
							rf_wa = ir_q[11:9];
							rf_wd = npc + off9;
						end
						lc3b_pkg::OP_TRAP: begin
							rf_we = 1'b1;
							rf_wa = 3'd7;
							rf_wd = npc;
							pc_d = 16'd0;
						end
						default: pc_d = npc;
					endcase
				end
			end
			ST_MEMW: begin
				if (out_free) begin
					done = 1'b1;
					st_d = ST_IDLE;
					pc_d = npc;
					if (op == lc3b_pkg::OP_STB) begin
						m_wd = ea_q[0] ? {rb_q[7:0], rdw[7:0]} : {rdw[15:8], rb_q[7:0]};
						m_we = lc3b_pkg::addr_in_range(ea_q);
						m_addr = lc3b_pkg::word_idx(ea_q);
						o.mem_written = m_we;
						o.mem_address = m_we ? ea_q : 16'd0;
						o.mem_value = m_we ? m_wd : 16'd0;
					end else begin
						rf_we = 1'b1;
						rf_wa = ir_q[11:9];
						cc_we = 1'b1;
						if (op == lc3b_pkg::OP_LDW)
							rf_wd = rdw;
						else if (ea_q[0])
							rf_wd = {{8{rdw[15]}}, rdw[15:8]};
						else
							rf_wd = {{8{rdw[7]}}, rdw[7:0]};
					end
				end
			end
			default: st_d = ST_IDLE;
		endcase

		if (cc_we) cc_d = codes(rf_wd);
		if (st_q == ST_EXEC || st_q == ST_MEMW) begin
			o.pc = pc_d;
			o.cond_neg = cc_d[2];
			o.cond_zero = cc_d[1];
			o.cond_pos = cc_d[0];
			o.reg_written = rf_we;
			o.reg_index = rf_we ? rf_wa : 3'd0;
			o.reg_value = rf_we ? rf_wd : 16'd0;
		end
	end

	always_ff @(posedge clk) begin
		if (m_we) mem[m_addr] <= m_wd;
		if (m_re) m_rd_q <= mem[m_addr];
		if (rf_we) rf_q[rf_wa] <= rf_wd;
		if (ea_ld) ea_q <= ea_d;
		if (ir_ld) begin
			ir_q <= rdw;
			ra_q <= rf_vld_q[ra_idx] ? rf_q[ra_idx] : 16'd0;
			rb_q <= rf_vld_q[rb_idx] ? rf_q[rb_idx] : 16'd0;
		end
		if (done) out_q <= o;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
			clr_q <= '0;
			rd_ok_q <= 1'b0;
			rf_vld_q <= '0;
			pc_q <= 16'd0;
			n_q <= 1'b0;
			z_q <= 1'b1;
			p_q <= 1'b0;
			started_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
			rd_ok_q <= rd_ok_d;
			if (rf_we) rf_vld_q[rf_wa] <= 1'b1;
			if (done) begin
				pc_q <= pc_d;
				{n_q, z_q, p_q} <= cc_d;
			end else begin
				pc_q <= pc_d;
			end
			if (started_set) started_q <= 1'b1;
			if (done) out_vld_q <= 1'b1;
			else if (out_ready) out_vld_q <= 1'b0;
		end
	end

endmodule

// ===== rtl/lc3b_instruction_executor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lc3b_instruction_executor_top
// LC-3b core: front queue, execution back end and the start_pc register.
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// in        in   in_valid / in_ready    lc3b_pkg::in_item_t
// out       out  out_valid / out_ready  lc3b_pkg::out_item_t
// cfg       in   cfg_valid / cfg_ready  start_pc (16 bits)
//
// After reset the back end clears main memory, one word a cycle, all MEM_WORDS
// (32768) words; meanwhile the queue takes up to two input transactions, cfg writes go in.
// Load, halt and invalid kinds finish in IDLE. Read: IDLE, then RDW. Execute: IDLE, FETCH,
// EXEC, plus MEMW for LDB/STB/LDW; set by the single memory port (fetch, then data access).
// A full output register stalls the back end; the 2-entry queue keeps input open.
// ----------------------------------------------------------------------------
module lc3b_instruction_executor_top (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lc3b_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lc3b_pkg::out_item_t out_data,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);

	logic [15:0] start_pc_q;
	logic        q_valid, q_ready;
	lc3b_pkg::q_item_t q_data;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) start_pc_q <= 16'd0;
		else if (cfg_valid && cfg_ready) start_pc_q <= cfg_data;
	end

	lc3b_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_data   (q_data)
	);

	lc3b_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.start_pc  (start_pc_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_data    (q_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule
